// ===== hw/rtl/utc_clock_servo_macros.svh =====
// Assertion macros for the UTC clock servo.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef UTC_CLOCK_SERVO_MACROS_SVH
`define UTC_CLOCK_SERVO_MACROS_SVH
`ifndef SYNTH
`define UCS_ASSERT_IMPL(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("ucs assertion failed");
`define UCS_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("ucs assertion failed");
`else
`define UCS_ASSERT_IMPL(lbl, ck, rs, pre, post)
`define UCS_ASSERT_NEXT(lbl, ck, rs, pre, post)
`endif
`endif

// ===== hw/rtl/ucs_pkg.sv =====
// Shared types and constants for the UTC clock servo.
// No dependencies; imported by every module of the block.
package ucs_pkg;

  localparam int RATIO_FRAC_BITS = 30;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 2;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  // proportional scaling: 1e6 * 65536 / 2^22 = 15625, then shift by 22 - F
  localparam logic [63:0] PROP_SCALE = 64'd15625;
  localparam int PROP_SH_L = (RATIO_FRAC_BITS <= 22) ? 22 - RATIO_FRAC_BITS : 0;
  localparam int PROP_SH_R = (RATIO_FRAC_BITS > 22) ? RATIO_FRAC_BITS - 22 : 0;

  localparam logic [40:0] TERM_SAT = 41'h100_0000_0000;

  localparam int DIV_STEPS = 64 + RATIO_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_CNT_W = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_RATE      = 3'd5;

  localparam logic [39:0] RST_STEP_THRESHOLD = 40'd1000000000;
  localparam logic [7:0]  RST_MISS_LIMIT     = 8'd10;
  localparam logic [9:0]  RST_FREQ_LIMIT     = 10'd250;
  localparam logic [31:0] RST_INTEGRAL_GAIN  = 32'd1288490;
  localparam logic [19:0] RST_PROP_GAIN      = 20'd65536;
  localparam logic [23:0] RST_SYNC_RATE      = 24'd65536;

  typedef enum logic [4:0] {
    OP_NONE, OP_RATE_DIV, OP_AGE_MUL, OP_EXPECT, OP_PHASE, OP_MAG, OP_DECIDE,
    OP_LR_DIV, OP_KI_MUL, OP_RATE_MUL, OP_TOP_MUL, OP_TERMS, OP_FRAC_MUL,
    OP_KP_MUL, OP_ACC, OP_CLAMP, OP_PUBLISH
  } op_e_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_RDIV_GO, S_RDIV_WAIT, S_AGE, S_AMUL_GO, S_AMUL_WAIT,
    S_EXPECT, S_PHASE, S_MAG, S_DECIDE, S_BRANCH, S_LDIV_GO, S_LDIV_WAIT,
    S_KI_GO, S_KI_WAIT, S_RT_GO, S_RT_WAIT, S_TOP_GO, S_TOP_WAIT, S_TERMS,
    S_FRAC_GO, S_FRAC_WAIT, S_KP_GO, S_KP_WAIT, S_ACC, S_CLAMP, S_PUB
  } state_t;

  typedef struct packed {
    op_e_t op;
    logic  load;
    logic  start;
    logic  publish;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic den_zero;
    logic locked;
    logic do_step;
    logic lr_ok;
    logic div_done;
    logic mul_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/ucs_div.sv =====
// Restoring divider giving n/d as unsigned Q2.F, saturated below 4.0.
// Depends on ucs_pkg; one quotient bit per cycle.
`include "utc_clock_servo_macros.svh"
module ucs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 num_in,
  input  logic [63:0]                 den_in,
  output logic                        done,
  output logic [ucs_pkg::RATIO_W-1:0] quo_out
);
  import ucs_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [63:0]          num;
  logic [63:0]          den;
  logic [63:0]          rem;
  logic [RATIO_W-1:0]   quo;
  logic                 ovf;
  logic [64:0]          shifted;
  logic                 ge;

  assign shifted = {rem, num[63]};
  assign ge      = shifted >= {1'b0, den};
  assign quo_out = ovf ? RATIO_MAX : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= num_in;
      den <= den_in;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      rem <= ge ? 64'(shifted - {1'b0, den}) : shifted[63:0];
      quo <= {quo[RATIO_W-2:0], ge};
      // any bit pushed out of the top means the integer part reached 4
      ovf <= ovf | quo[RATIO_W-1];
    end
  end

  `UCS_ASSERT_IMPL(a_div_start_idle, clk, rst, start, !busy)

endmodule

// ===== hw/rtl/ucs_mul.sv =====
// Shift-add 64x64 multiplier, one multiplier bit per cycle, 128-bit product.
// Depends on ucs_pkg.
`include "utc_clock_servo_macros.svh"
module ucs_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a_in,
  input  logic [63:0] b_in,
  output logic        done,
  output logic [63:0] prod_hi,
  output logic [63:0] prod_lo
);
  import ucs_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [63:0]          a;
  logic [63:0]          b;
  logic [64:0]          sum;

  assign sum = {1'b0, prod_hi} + {1'b0, (b[0] ? a : 64'd0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a       <= a_in;
      b       <= b_in;
      prod_hi <= '0;
      prod_lo <= '0;
    end else if (busy) begin
      prod_hi <= sum[64:1];
      prod_lo <= {sum[0], prod_lo[63:1]};
      b       <= {1'b0, b[63:1]};
    end
  end

  `UCS_ASSERT_IMPL(a_mul_start_idle, clk, rst, start, !busy)

endmodule

// ===== hw/rtl/ucs_datapath.sv =====
// Servo datapath: config registers, loop state, working registers, result register.
// Depends on ucs_pkg, ucs_div and ucs_mul; driven by ucs_ctrl commands.
`include "utc_clock_servo_macros.svh"
module ucs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ucs_pkg::dp_cmd_t              cmd,
  output ucs_pkg::dp_status_t           status,
  input  logic                          cfg_we,
  input  logic [ucs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ucs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [63:0]                   utc_ns,
  input  logic [63:0]                   ptp_at_utc_ns,
  input  logic [63:0]                   ptp_now_ns,
  input  logic                          ptp_locked,
  input  logic [63:0]                   local_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          action,
  output logic signed [63:0]            step_offset_ns,
  output logic signed [26:0]            freq_adj_q16,
  output logic                          ratio_rejected,
  output logic [63:0]                   expected_utc_ns,
  output logic [63:0]                   ptp_time_out_ns
);
  import ucs_pkg::*;

  // configuration
  logic [39:0] step_threshold;
  logic [7:0]  miss_limit;
  logic [9:0]  freq_limit;
  logic [31:0] integral_gain;
  logic [19:0] prop_gain;
  logic [23:0] sync_rate;

  // loop state
  logic [63:0]        last_utc;
  logic [63:0]        last_ptp;
  logic [63:0]        last_local;
  logic [RATIO_W-1:0] rate_ratio;
  logic [26:0]        accum;
  logic [7:0]         clamp_count;

  // latched update
  logic [63:0] utc;
  logic [63:0] ptp_at;
  logic [63:0] ptp_now;
  logic [63:0] local_t;
  logic        locked;
  logic        first;

  // working registers
  logic [63:0]        age_prod;
  logic [63:0]        expected;
  logic [63:0]        pe;
  logic [63:0]        pe_mag;
  logic [63:0]        lr_n;
  logic [63:0]        lr_d;
  logic               do_step;
  logic               lr_ok;
  logic               rejected;
  logic [RATIO_W-1:0] rq;
  logic [63:0]        h1;
  logic [63:0]        l1;
  logic [63:0]        h2;
  logic [63:0]        l2;
  logic [63:0]        top;
  logic [40:0]        imag;
  logic               frac_neg;
  logic [63:0]        fmag;
  logic [63:0]        x;
  logic [40:0]        pmag;
  logic signed [43:0] acc_sum;
  logic [26:0]        accum_new;
  logic [7:0]         clamp_new;

  // units
  logic               div_start;
  logic [63:0]        div_n;
  logic [63:0]        div_d;
  logic               div_done;
  logic [RATIO_W-1:0] div_q;
  logic               mul_start;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic               mul_done;
  logic [63:0]        mul_hi;
  logic [63:0]        mul_lo;

  logic [63:0]        den;
  logic [63:0]        age;
  logic [63:0]        age_mag;
  logic [127:0]       product;
  logic [47:0]        kp_shift;
  logic signed [43:0] lim_s;
  logic [43:0]        imag_term;
  logic [43:0]        prop_term;
  logic               lr_ok_c;

  assign den      = ptp_at - last_ptp;
  assign age      = ptp_now - ptp_at;
  assign age_mag  = age[63] ? 64'd0 - age : age;
  assign product  = {mul_hi, mul_lo};
  assign kp_shift = mul_lo[63:16];
  assign lim_s    = $signed({18'd0, freq_limit, 16'd0});
  assign imag_term = pe[63] ? 44'd0 - 44'(imag) : 44'(imag);
  assign prop_term = frac_neg ? 44'd0 - 44'(pmag) : 44'(pmag);
  assign lr_ok_c  = (lr_d != 64'd0)
                 && (lr_n >= ({1'b0, lr_d[63:1]} + {63'd0, lr_d[0]}))
                 && (lr_d[63] || (lr_n <= {lr_d[62:0], 1'b0}));

  assign status.first    = first;
  assign status.den_zero = (den == 64'd0);
  assign status.locked   = locked;
  assign status.do_step  = do_step;
  assign status.lr_ok    = lr_ok;
  assign status.div_done = div_done;
  assign status.mul_done = mul_done;
  assign status.out_busy = out_valid && !out_ready;

  // unit operand selection
  always_comb begin
    div_start = cmd.start && (cmd.op == OP_RATE_DIV || cmd.op == OP_LR_DIV);
    div_n     = lr_n;
    div_d     = lr_d;
    if (cmd.op == OP_RATE_DIV) begin
      div_n = utc - last_utc;
      div_d = den;
    end
    mul_start = cmd.start && !div_start;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd.op)
      OP_AGE_MUL: begin
        mul_a = age_mag;
        mul_b = 64'(rate_ratio);
      end
      OP_KI_MUL: begin
        mul_a = pe_mag;
        mul_b = 64'(integral_gain);
      end
      OP_RATE_MUL: begin
        mul_a = l1;
        mul_b = 64'(sync_rate);
      end
      OP_TOP_MUL: begin
        mul_a = h1;
        mul_b = 64'(sync_rate);
      end
      OP_FRAC_MUL: begin
        mul_a = fmag;
        mul_b = PROP_SCALE;
      end
      OP_KP_MUL: begin
        mul_a = x;
        mul_b = 64'(prop_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ucs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_in  (div_n),
    .den_in  (div_d),
    .done    (div_done),
    .quo_out (div_q)
  );

  ucs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .done    (mul_done),
    .prod_hi (mul_hi),
    .prod_lo (mul_lo)
  );

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold <= RST_STEP_THRESHOLD;
      miss_limit     <= RST_MISS_LIMIT;
      freq_limit     <= RST_FREQ_LIMIT;
      integral_gain  <= RST_INTEGRAL_GAIN;
      prop_gain      <= RST_PROP_GAIN;
      sync_rate      <= RST_SYNC_RATE;
      last_utc       <= '0;
      last_ptp       <= '0;
      last_local     <= '0;
      rate_ratio     <= RATIO_ONE;
      accum          <= '0;
      clamp_count    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_THRESHOLD: step_threshold <= cfg_data[39:0];
          REG_MISS_LIMIT:     miss_limit     <= cfg_data[7:0];
          REG_FREQ_LIMIT:     freq_limit     <= cfg_data[9:0];
          REG_INTEGRAL_GAIN:  integral_gain  <= cfg_data[31:0];
          REG_PROP_GAIN:      prop_gain      <= cfg_data[19:0];
          REG_SYNC_RATE:      sync_rate      <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_RATE_DIV && div_done) begin
        rate_ratio <= div_q;
      end
      if (cmd.publish) begin
        last_utc    <= utc;
        last_ptp    <= ptp_at;
        last_local  <= local_t;
        accum       <= do_step ? accum : accum_new;
        clamp_count <= do_step ? 8'd0 : clamp_new;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      utc     <= utc_ns;
      ptp_at  <= ptp_at_utc_ns;
      ptp_now <= ptp_now_ns;
      local_t <= local_ns;
      locked  <= ptp_locked;
      first   <= (last_utc == 64'd0);
    end
    if (mul_done) begin
      case (cmd.op)
        OP_AGE_MUL:  age_prod <= product[RATIO_FRAC_BITS+63:RATIO_FRAC_BITS];
        OP_KI_MUL: begin
          h1 <= mul_hi;
          l1 <= mul_lo;
        end
        OP_RATE_MUL: begin
          h2 <= mul_hi;
          l2 <= mul_lo;
        end
        OP_TOP_MUL:  top <= mul_lo + h2;
        OP_FRAC_MUL: x <= (mul_lo << PROP_SH_L) >> PROP_SH_R;
        OP_KP_MUL:   pmag <= ({1'b0, kp_shift} > 49'(TERM_SAT)) ? TERM_SAT
                                                               : 41'(kp_shift);
        default: ;
      endcase
    end
    if (cmd.op == OP_LR_DIV && div_done) begin
      rq <= div_q;
    end
    case (cmd.op)
      OP_EXPECT: begin
        expected <= !locked ? utc
                  : utc + (age[63] ? 64'd0 - age_prod : age_prod);
      end
      OP_PHASE: begin
        pe   <= expected - local_t;
        lr_n <= expected - last_local;
        lr_d <= local_t - last_local;
      end
      OP_MAG: pe_mag <= pe[63] ? 64'd0 - pe : pe;
      OP_DECIDE: begin
        do_step  <= (pe_mag > {24'd0, step_threshold}) || first
                 || (clamp_count > miss_limit);
        lr_ok    <= lr_ok_c;
        rejected <= !lr_ok_c;
        rq       <= RATIO_ONE;
      end
      OP_TERMS: begin
        imag     <= (h1[63:32] != 32'd0 || top[63:8] != 56'd0) ? TERM_SAT
                  : {1'b0, top[7:0], l2[63:32]};
        frac_neg <= rq < RATIO_ONE;
        fmag     <= (rq < RATIO_ONE) ? 64'(RATIO_ONE - rq) : 64'(rq - RATIO_ONE);
      end
      OP_ACC: acc_sum <= $signed({{17{accum[26]}}, accum} + imag_term + prop_term);
      OP_CLAMP: begin
        if (acc_sum < -lim_s) begin
          accum_new <= 27'(-lim_s);
          clamp_new <= (clamp_count == 8'hff) ? clamp_count : clamp_count + 8'd1;
        end else if (acc_sum > lim_s) begin
          accum_new <= 27'(lim_s);
          clamp_new <= (clamp_count == 8'hff) ? clamp_count : clamp_count + 8'd1;
        end else begin
          accum_new <= acc_sum[26:0];
          clamp_new <= 8'd0;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      action          <= !do_step;
      step_offset_ns  <= $signed(pe);
      freq_adj_q16    <= do_step ? 27'sd0 : $signed(accum_new);
      ratio_rejected  <= !do_step && rejected;
      expected_utc_ns <= expected;
      ptp_time_out_ns <= ptp_now;
    end
  end

  `UCS_ASSERT_IMPL(a_publish_slot_free, clk, rst, cmd.publish, !out_valid || out_ready)
  `UCS_ASSERT_IMPL(a_units_exclusive, clk, rst, div_start, !mul_start)

endmodule

// ===== hw/rtl/ucs_ctrl.sv =====
// Servo sequencer: walks one update through the datapath steps.
// Depends on ucs_pkg; drives ucs_datapath through dp_cmd_t.
`include "utc_clock_servo_macros.svh"
module ucs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                update_valid,
  input  ucs_pkg::dp_status_t status,
  output ucs_pkg::dp_cmd_t    cmd
);
  import ucs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid && update_valid) state_next = S_RATE;
      S_RATE:      state_next = (!status.first && !status.den_zero) ? S_RDIV_GO : S_AGE;
      S_RDIV_GO:   state_next = S_RDIV_WAIT;
      S_RDIV_WAIT: if (status.div_done) state_next = S_AGE;
      S_AGE:       state_next = status.locked ? S_AMUL_GO : S_EXPECT;
      S_AMUL_GO:   state_next = S_AMUL_WAIT;
      S_AMUL_WAIT: if (status.mul_done) state_next = S_EXPECT;
      S_EXPECT:    state_next = S_PHASE;
      S_PHASE:     state_next = S_MAG;
      S_MAG:       state_next = S_DECIDE;
      S_DECIDE:    state_next = S_BRANCH;
      S_BRANCH: begin
        if (status.do_step) state_next = S_PUB;
        else if (status.lr_ok) state_next = S_LDIV_GO;
        else state_next = S_KI_GO;
      end
      S_LDIV_GO:   state_next = S_LDIV_WAIT;
      S_LDIV_WAIT: if (status.div_done) state_next = S_KI_GO;
      S_KI_GO:     state_next = S_KI_WAIT;
      S_KI_WAIT:   if (status.mul_done) state_next = S_RT_GO;
      S_RT_GO:     state_next = S_RT_WAIT;
      S_RT_WAIT:   if (status.mul_done) state_next = S_TOP_GO;
      S_TOP_GO:    state_next = S_TOP_WAIT;
      S_TOP_WAIT:  if (status.mul_done) state_next = S_TERMS;
      S_TERMS:     state_next = S_FRAC_GO;
      S_FRAC_GO:   state_next = S_FRAC_WAIT;
      S_FRAC_WAIT: if (status.mul_done) state_next = S_KP_GO;
      S_KP_GO:     state_next = S_KP_WAIT;
      S_KP_WAIT:   if (status.mul_done) state_next = S_ACC;
      S_ACC:       state_next = S_CLAMP;
      S_CLAMP:     state_next = S_PUB;
      S_PUB:       if (!status.out_busy) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    cmd.op      = OP_NONE;
    cmd.load    = (state == S_IDLE) && in_valid;
    cmd.start   = 1'b0;
    cmd.publish = 1'b0;
    unique case (state)
      S_RDIV_GO:   begin cmd.op = OP_RATE_DIV; cmd.start = 1'b1; end
      S_RDIV_WAIT: cmd.op = OP_RATE_DIV;
      S_AMUL_GO:   begin cmd.op = OP_AGE_MUL; cmd.start = 1'b1; end
      S_AMUL_WAIT: cmd.op = OP_AGE_MUL;
      S_EXPECT:    cmd.op = OP_EXPECT;
      S_PHASE:     cmd.op = OP_PHASE;
      S_MAG:       cmd.op = OP_MAG;
      S_DECIDE:    cmd.op = OP_DECIDE;
      S_LDIV_GO:   begin cmd.op = OP_LR_DIV; cmd.start = 1'b1; end
      S_LDIV_WAIT: cmd.op = OP_LR_DIV;
      S_KI_GO:     begin cmd.op = OP_KI_MUL; cmd.start = 1'b1; end
      S_KI_WAIT:   cmd.op = OP_KI_MUL;
      S_RT_GO:     begin cmd.op = OP_RATE_MUL; cmd.start = 1'b1; end
      S_RT_WAIT:   cmd.op = OP_RATE_MUL;
      S_TOP_GO:    begin cmd.op = OP_TOP_MUL; cmd.start = 1'b1; end
      S_TOP_WAIT:  cmd.op = OP_TOP_MUL;
      S_TERMS:     cmd.op = OP_TERMS;
      S_FRAC_GO:   begin cmd.op = OP_FRAC_MUL; cmd.start = 1'b1; end
      S_FRAC_WAIT: cmd.op = OP_FRAC_MUL;
      S_KP_GO:     begin cmd.op = OP_KP_MUL; cmd.start = 1'b1; end
      S_KP_WAIT:   cmd.op = OP_KP_MUL;
      S_ACC:       cmd.op = OP_ACC;
      S_CLAMP:     cmd.op = OP_CLAMP;
      S_PUB:       begin cmd.op = OP_PUBLISH; cmd.publish = !status.out_busy; end
      default:     cmd.op = OP_NONE;
    endcase
  end

  `UCS_ASSERT_NEXT(a_valid_update_taken, clk, rst, in_valid && in_ready && update_valid, state == S_RATE)

endmodule

// ===== hw/rtl/utc_clock_servo.sv =====
// Top level of the UTC clock servo: sequencer plus datapath.
// Depends on ucs_pkg, ucs_ctrl and ucs_datapath.
//
//  channel | signals                                   | direction
//  input   | in_valid/in_ready, update fields          | in
//  result  | out_valid/out_ready, command fields       | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
// An update is taken only when the sequencer is idle; an update with update_valid low
// is taken and gives nothing, and the sequencer stays idle. A valid update runs the rate
// division when it has a previous sample with a nonzero PTP interval, a multiply when
// locked, then a step decision; a slew adds the local-rate division when the local ratio
// is in range, and five multiplies. A step is published straight after the decision and
// a slew after the clamp; the sequencer then returns to idle and takes the next update.
// Reset is synchronous and restores defaults; no clearing pass. The result register lets
// the next update be taken while a result waits; a stalled result holds publication.
module utc_clock_servo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          update_valid,
  input  logic [63:0]                   utc_ns,
  input  logic [63:0]                   ptp_at_utc_ns,
  input  logic [63:0]                   ptp_now_ns,
  input  logic                          ptp_locked,
  input  logic [63:0]                   local_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          action,
  output logic signed [63:0]            step_offset_ns,
  output logic signed [26:0]            freq_adj_q16,
  output logic                          ratio_rejected,
  output logic [63:0]                   expected_utc_ns,
  output logic [63:0]                   ptp_time_out_ns,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ucs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ucs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ucs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // config writes are always accepted, never stalled
  assign cfg_ready = 1'b1;

  ucs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .update_valid (update_valid),
    .status       (status),
    .cmd          (cmd)
  );

  ucs_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .utc_ns          (utc_ns),
    .ptp_at_utc_ns   (ptp_at_utc_ns),
    .ptp_now_ns      (ptp_now_ns),
    .ptp_locked      (ptp_locked),
    .local_ns        (local_ns),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .step_offset_ns  (step_offset_ns),
    .freq_adj_q16    (freq_adj_q16),
    .ratio_rejected  (ratio_rejected),
    .expected_utc_ns (expected_utc_ns),
    .ptp_time_out_ns (ptp_time_out_ns)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for utc_clock_servo: directed table, then phased random traffic.
// Predicts each command from its own servo model. Depends on ucs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import ucs_pkg::*;

  localparam int  SETTLE     = 800;
  localparam int  WDOG_LIMIT = 20000;
  localparam int  MAX_GAP    = 20;
  localparam int  PHASE_ITEMS = 285;
  localparam logic [63:0] GIGA = 64'd1000000000;
  localparam logic [63:0] MAG_SAT = 64'h100_0000_0000;

  typedef struct {
    bit        uv;
    bit [63:0] utc;
    bit [63:0] ptp_at;
    bit [63:0] ptp_now;
    bit        locked;
    bit [63:0] loc;
  } update_t;

  typedef struct {
    bit        action;
    bit [63:0] offset;
    bit [26:0] freq;
    bit        rejected;
    bit [63:0] exp_utc;
    bit [63:0] ptp_now;
  } command_t;

  typedef struct {
    update_t   u;
    bit        typed;
    bit        action;
    bit [63:0] offset;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic update_valid = 1'b0;
  logic [63:0] utc_ns = '0;
  logic [63:0] ptp_at_utc_ns = '0;
  logic [63:0] ptp_now_ns = '0;
  logic ptp_locked = 1'b0;
  logic [63:0] local_ns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic action;
  logic signed [63:0] step_offset_ns;
  logic signed [26:0] freq_adj_q16;
  logic ratio_rejected;
  logic [63:0] expected_utc_ns;
  logic [63:0] ptp_time_out_ns;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  utc_clock_servo dut (.*);

  always #6 clk = ~clk;

  // servo model state and registers
  bit [39:0] thr_ns;
  bit [7:0]  miss_lim;
  bit [9:0]  flim_ppm;
  bit [31:0] ki_q32;
  bit [19:0] kp_q16;
  bit [23:0] rate_q16;
  bit [63:0] prev_utc, prev_ptp, prev_loc;
  bit [31:0] utc_ratio;
  longint    accum_q16;
  bit [7:0]  clamps;

  command_t pending_cmds[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  bit [63:0] sc_utc, sc_ptp;

  function automatic bit [63:0] ratio_q(bit [63:0] n, bit [63:0] d);
    bit [127:0] q;
    if (n / d >= 4) return (64'd4 << RATIO_FRAC_BITS) - 1;
    q = ({64'd0, n} << RATIO_FRAC_BITS) / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic longint signed_term(bit [63:0] mag, bit neg);
    if (mag > MAG_SAT) mag = MAG_SAT;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  task automatic servo_predict(input update_t u);
    command_t c;
    bit [63:0] age, amag, prod, pe, pe_mag, n, d, rq, imag, fmag, x;
    bit [127:0] wide;
    bit neg, first, ok;
    longint frac, acc, lim;
    if (!u.uv) return;
    c = '{default: 0};
    c.ptp_now = u.ptp_now;
    first = (prev_utc == 0);
    if (!first && (u.ptp_at - prev_ptp) != 0)
      utc_ratio = 32'(ratio_q(u.utc - prev_utc, u.ptp_at - prev_ptp));
    c.exp_utc = u.utc;
    if (u.locked) begin
      age = u.ptp_now - u.ptp_at;
      neg = age[63];
      amag = neg ? -age : age;
      wide = {64'd0, amag} * {96'd0, utc_ratio};
      prod = wide[RATIO_FRAC_BITS +: 64];
      c.exp_utc = u.utc + (neg ? -prod : prod);
    end
    pe = c.exp_utc - u.loc;
    pe_mag = pe[63] ? -pe : pe;
    c.offset = pe;
    if (pe_mag > {24'd0, thr_ns} || first || clamps > miss_lim) begin
      c.action = 1'b0;
      clamps = 0;
    end else begin
      c.action = 1'b1;
      n = c.exp_utc - prev_loc;
      d = u.loc - prev_loc;
      ok = d != 0 && n >= (d >> 1) + d[0] && (d[63] || n <= (d << 1));
      rq = 64'd1 << RATIO_FRAC_BITS;
      if (ok) rq = ratio_q(n, d);
      else c.rejected = 1'b1;
      wide = {64'd0, pe_mag} * {96'd0, ki_q32} * {104'd0, rate_q16};
      imag = (wide >> 72) != 0 ? MAG_SAT : wide[95:32];
      frac = longint'(rq) - (longint'(1) << RATIO_FRAC_BITS);
      fmag = frac < 0 ? -frac : frac;
      x = ((fmag * 64'd15625) >> 8) * kp_q16 >> 16;
      acc = accum_q16 + signed_term(imag, pe[63]) + signed_term(x, frac < 0);
      lim = longint'(flim_ppm) * 65536;
      if (acc < -lim || acc > lim) begin
        acc = acc < 0 ? -lim : lim;
        if (clamps != 8'hff) clamps++;
      end else begin
        clamps = 0;
      end
      accum_q16 = acc;
      c.freq = acc[26:0];
    end
    prev_utc = u.utc;
    prev_ptp = u.ptp_at;
    prev_loc = u.loc;
    pending_cmds.push_back(c);
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP_THRESHOLD: thr_ns   = val[39:0];
      REG_MISS_LIMIT:     miss_lim = val[7:0];
      REG_FREQ_LIMIT:     flim_ppm = val[9:0];
      REG_INTEGRAL_GAIN:  ki_q32   = val[31:0];
      REG_PROP_GAIN:      kp_q16   = val[19:0];
      REG_SYNC_RATE:      rate_q16 = val[23:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [39:0] thr, logic [7:0] ml, logic [9:0] fl,
                         logic [31:0] ki, logic [19:0] kp, logic [23:0] sr);
    cfg_write(REG_STEP_THRESHOLD, thr);
    cfg_write(REG_MISS_LIMIT, 40'(ml));
    cfg_write(REG_FREQ_LIMIT, 40'(fl));
    cfg_write(REG_INTEGRAL_GAIN, 40'(ki));
    cfg_write(REG_PROP_GAIN, 40'(kp));
    cfg_write(REG_SYNC_RATE, 40'(sr));
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Returns with the update accepted; in_valid stays high for a back-to-back transfer.
  task automatic send_update(update_t u);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    update_valid  <= u.uv;
    utc_ns        <= u.utc;
    ptp_at_utc_ns <= u.ptp_at;
    ptp_now_ns    <= u.ptp_now;
    ptp_locked    <= u.locked;
    local_ns      <= u.loc;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    servo_predict(u);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic update_t make_update();
    update_t u;
    bit [63:0] err;
    int kind;
    kind = $urandom_range(99);
    u.uv = 1'b1;
    if (kind < 15) begin
      // noise: anything the fields allow, some of it not a real update
      u = '{1'b0, rand64(), rand64(), rand64(), 1'b0, rand64()};
      u.uv = 1'($urandom_range(1));
      u.locked = 1'($urandom_range(1));
      return u;
    end
    sc_utc += GIGA + $urandom_range(2000) - 1000;
    sc_ptp += GIGA + $urandom_range(400) - 200;
    u.utc = kind < 18 ? 64'd0 : sc_utc;
    u.ptp_at = sc_ptp;
    u.ptp_now = sc_ptp + $urandom_range(200000);
    if (kind < 22) u.ptp_now = sc_ptp - $urandom_range(5000);
    u.locked = $urandom_range(3) != 0;
    case ($urandom_range(9))
      0:       err = {32'd0, $urandom} << $urandom_range(2);
      1:       err = 64'd0;
      default: err = 64'($urandom_range(60000));
    endcase
    if ($urandom_range(1)) err = -err;
    u.loc = sc_utc + (u.locked ? u.ptp_now - sc_ptp : 64'd0) - err;
    return u;
  endfunction

  task automatic random_phase(int count, bit hold_midway);
    update_t u;
    int done;
    done = 0;
    while (done < count) begin
      u = make_update();
      send_update(u);
      if (u.uv) done++;
      if (hold_midway && done == count / 2) begin
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  dir_row_t dir_tab[] = '{
    '{'{1'b0, 64'd77, 64'd5, 64'd9, 1'b1, 64'd3}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd1000, 64'd0, 64'd0, 1'b0, 64'd400}, 1'b1, 1'b0, 64'd600},
    '{'{1'b1, 64'd0, 64'd0, 64'd0, 1'b0, 64'd5}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, '1, '1, '1, 1'b1, 64'd0}, 1'b1, 1'b0, '1},
    '{'{1'b1, 64'd9000000000, 64'd9000000000, 64'd9000000000, 1'b0,
        64'd1000000000}, 1'b1, 1'b0, 64'd8000000000},
    '{'{1'b1, 64'd10000000000, 64'd10000000000, 64'd10000000000, 1'b0,
        64'd20000000000}, 1'b1, 1'b0, -64'd10000000000},
    '{'{1'b1, 64'd11000000000, 64'd11000000000, 64'd11000002000, 1'b1,
        64'd11000001500}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd12000000100, 64'd12000000000, 64'd12000000000, 1'b1,
        64'd12000000000}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd13000000000, 64'd13000000000, 64'd12999990000, 1'b1,
        64'd12000000000}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd14000000000, 64'd13000000001, 64'd13000000001, 1'b0,
        64'd13999999000}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd15000000000, 64'd14000000000, 64'd14000000000, 1'b0,
        64'd15000000000}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd16000000000, 64'd15000000000, 64'd15000000000, 1'b1,
        64'd15999990000}, 1'b0, 1'b0, 64'd0},
    '{'{1'b0, 64'd1, 64'd1, 64'd1, 1'b0, 64'd1}, 1'b0, 1'b0, 64'd0},
    '{'{1'b1, 64'd17000000000, 64'd16000000000, 64'd16000000000, 1'b0,
        64'd16999999900}, 1'b0, 1'b0, 64'd0}
  };

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    command_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        report("unexpected transfer", 64'(action), 64'd0);
      end else begin
        e = pending_cmds.pop_front();
        if (action !== e.action) report("action", 64'(action), 64'(e.action));
        if (step_offset_ns !== e.offset) report("step_offset_ns", step_offset_ns, e.offset);
        if (freq_adj_q16 !== e.freq) report("freq_adj_q16", 64'(freq_adj_q16), 64'(e.freq));
        if (ratio_rejected !== e.rejected)
          report("ratio_rejected", 64'(ratio_rejected), 64'(e.rejected));
        if (expected_utc_ns !== e.exp_utc)
          report("expected_utc_ns", expected_utc_ns, e.exp_utc);
        if (ptp_time_out_ns !== e.ptp_now)
          report("ptp_time_out_ns", ptp_time_out_ns, e.ptp_now);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    thr_ns = RST_STEP_THRESHOLD;
    miss_lim = RST_MISS_LIMIT;
    flim_ppm = RST_FREQ_LIMIT;
    ki_q32 = RST_INTEGRAL_GAIN;
    kp_q16 = RST_PROP_GAIN;
    rate_q16 = RST_SYNC_RATE;
    prev_utc = 0;
    prev_ptp = 0;
    prev_loc = 0;
    utc_ratio = RATIO_ONE;
    accum_q16 = 0;
    clamps = 0;
    sc_utc = rand64() >> 2;
    sc_ptp = rand64() >> 2;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults first; typed rows override the predicted command
    foreach (dir_tab[i]) begin
      send_update(dir_tab[i].u);
      if (dir_tab[i].typed) begin
        pending_cmds[$].action = dir_tab[i].action;
        pending_cmds[$].offset = dir_tab[i].offset;
      end
    end
    in_valid <= 1'b0;
    random_phase(PHASE_ITEMS, 1'b0);
    drain();

    cfg_all('1, 8'd0, 10'd1, '1, '1, '1);
    idle_pct = 53;
    random_phase(PHASE_ITEMS, 1'b0);
    drain();

    cfg_all('0, 8'd255, 10'd1000, '0, '0, '0);
    idle_pct = 0;
    stall_pct = 53;
    random_phase(PHASE_ITEMS, 1'b0);
    drain();

    cfg_all({8'($urandom_range(255)), $urandom}, 8'($urandom_range(20)),
            10'($urandom_range(1000)), 32'($urandom_range(20000000)), 20'($urandom),
            24'($urandom_range(1 << 20)));
    idle_pct = 32;
    stall_pct = 32;
    random_phase(PHASE_ITEMS, 1'b0);
    drain();

    cfg_all(40'd50000, 8'd3, 10'd5, 32'd200000000, 20'd65536, 24'd65536);
    idle_pct = 53;
    stall_pct = 53;
    random_phase(PHASE_ITEMS, 1'b1);
    drain();

    cfg_all(RST_STEP_THRESHOLD, 8'($urandom), 10'($urandom_range(1000)), $urandom,
            20'($urandom), 24'($urandom));
    idle_pct = 0;
    stall_pct = 0;
    random_phase(PHASE_ITEMS, 1'b0);
    drain();

    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
